FILE: src/issi_pkg.sv
// Package: types and constants shared by the interval set subtract/intersect core.
package issi_pkg;

  localparam int unsigned SetCapacity = 16;
  localparam int unsigned EndWidth    = 32;
  localparam int unsigned MaxOut      = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_LOAD_A = 2'd1,
    KIND_LOAD_B = 2'd2,
    KIND_RUN    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] lo_end;
    logic signed [31:0] hi_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_lo;
    logic signed [31:0] res_hi;
    logic               is_last;
    logic               is_empty;
    logic               overflowed;
  } out_item_t;

endpackage

FILE: src/interval_set_subtract_intersect_core.sv
// Top level: interval set subtract/intersect core with sequencer and stores.
//
// Load beats (clear, load A, load B) give no result, so they can follow back
// to back. A run beat sorts A then B in place by lower end with an insertion
// sort. It then sweeps both sets, one step at a time. A single shared signed
// compare unit makes every comparison of interval ends, with one compare per
// cycle. Each inserted entry is read, compared against the entries before it,
// each larger one shifting up a place, and then written into the gap. A run
// with B empty skips the sort. Each sweep step is one read and up to four
// compares. There are at most nA+nB steps. Results collect in a small buffer
// and then stream out one beat per accepted output cycle. overflowed is known
// only at the sweep end, so all results of a run that fit are buffered first.
// No input is taken during a run.
module interval_set_subtract_intersect_core #(
  parameter int unsigned SET_CAPACITY = issi_pkg::SetCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  issi_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output issi_pkg::out_item_t out_data_o
);
  import issi_pkg::*;

  localparam int unsigned IW   = $clog2(SET_CAPACITY);
  localparam int unsigned CW   = $clog2(SET_CAPACITY + 1);
  localparam int unsigned RCap = (SET_CAPACITY < MaxOut) ? SET_CAPACITY : MaxOut;
  localparam int unsigned RW   = (RCap > 1) ? $clog2(RCap) : 1;
  localparam int unsigned RCW  = $clog2(RCap + 1);
  localparam int unsigned EW   = EndWidth;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SORTI  = 11'b00000000010,
    S_SORTR  = 11'b00000000100,
    S_SORTC  = 11'b00000001000,
    S_SORTW  = 11'b00000010000,
    S_SWRD   = 11'b00000100000,
    S_SWC1   = 11'b00001000000,
    S_SWC2   = 11'b00010000000,
    S_SWC3   = 11'b00100000000,
    S_SWC4   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [EW-1:0] a_lo_q [SET_CAPACITY];
  logic [EW-1:0] a_hi_q [SET_CAPACITY];
  logic [EW-1:0] b_lo_q [SET_CAPACITY];
  logic [EW-1:0] b_hi_q [SET_CAPACITY];
  logic [EW-1:0] r_lo_q [RCap];
  logic [EW-1:0] r_hi_q [RCap];

  logic [CW-1:0]  a_cnt_q, b_cnt_q;
  logic           mode_q;
  logic           sel_b_q;          // sorting set B
  logic [CW-1:0]  si_q, sj_q;       // sort outer / inner index
  logic [EW-1:0]  kl_q, kh_q;       // key being inserted
  logic [CW-1:0]  ca_q, cb_q;
  logic [EW-1:0]  min_a_q, max_a_q, min_b_q, max_b_q;
  logic           fresh_q;
  logic [RCW-1:0] rn_q, oi_q;
  logic           over_q;
  logic           lt3_q;

  // shared compare unit operands
  logic [EW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;

  issi_cmp #(.EndWidth(EW)) u_cmp (.a_i(cmp_a), .b_i(cmp_b), .lt_o(cmp_lt));

  logic in_acc, out_acc, isect;
  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = state_q == S_OUT;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign isect       = mode_q;

  logic [CW-1:0] scnt;
  logic [IW-1:0] sj_m1;
  logic [EW-1:0] prev_lo;
  assign scnt    = sel_b_q ? b_cnt_q : a_cnt_q;
  assign sj_m1   = IW'(sj_q - CW'(1));
  assign prev_lo = sel_b_q ? b_lo_q[sj_m1] : a_lo_q[sj_m1];

  always_comb begin
    cmp_a = kl_q;
    cmp_b = prev_lo;
    unique case (state_q)
      S_SORTC: begin cmp_a = kl_q;    cmp_b = prev_lo; end // key < prev
      S_SWC1:  begin cmp_a = min_a_q; cmp_b = max_b_q; end // !(max_b<=min_a)
      S_SWC2:  begin cmp_a = min_b_q; cmp_b = max_a_q; end // min_b < max_a
      S_SWC3:  begin cmp_a = min_a_q; cmp_b = min_b_q; end // min_a < min_b
      S_SWC4:  begin cmp_a = max_b_q; cmp_b = max_a_q; end // max_b < max_a
      default: ;
    endcase
  end

  // result push helper signals
  logic          push;
  logic [EW-1:0] push_lo, push_hi;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.kind == KIND_LOAD_A && a_cnt_q < CW'(SET_CAPACITY)) begin
      a_lo_q[IW'(a_cnt_q)] <= EW'(in_data_i.lo_end);
      a_hi_q[IW'(a_cnt_q)] <= EW'(in_data_i.hi_end);
    end
    if (in_acc && in_data_i.kind == KIND_LOAD_B && b_cnt_q < CW'(SET_CAPACITY)) begin
      b_lo_q[IW'(b_cnt_q)] <= EW'(in_data_i.lo_end);
      b_hi_q[IW'(b_cnt_q)] <= EW'(in_data_i.hi_end);
    end
    if (state_q == S_SORTC && sj_q != '0 && cmp_lt) begin
      // shift prev up
      if (sel_b_q) begin
        b_lo_q[IW'(sj_q)] <= b_lo_q[sj_m1];
        b_hi_q[IW'(sj_q)] <= b_hi_q[sj_m1];
      end else begin
        a_lo_q[IW'(sj_q)] <= a_lo_q[sj_m1];
        a_hi_q[IW'(sj_q)] <= a_hi_q[sj_m1];
      end
    end
    if (state_q == S_SORTW) begin
      if (sel_b_q) begin
        b_lo_q[IW'(sj_q)] <= kl_q;
        b_hi_q[IW'(sj_q)] <= kh_q;
      end else begin
        a_lo_q[IW'(sj_q)] <= kl_q;
        a_hi_q[IW'(sj_q)] <= kh_q;
      end
    end
    if (push && rn_q < RCW'(RCap)) begin
      r_lo_q[RW'(rn_q)] <= push_lo;
      r_hi_q[RW'(rn_q)] <= push_hi;
    end
  end

  // sequencer
  logic [CW-1:0]  a_cnt_d, b_cnt_d, si_d, sj_d, ca_d, cb_d;
  logic           sel_b_d, fresh_d, over_d;
  logic [EW-1:0]  kl_d, kh_d, min_a_d, max_a_d, min_b_d, max_b_d;
  logic [RCW-1:0] rn_d, oi_d;
  logic           lt3_d;

  always_comb begin
    state_d = state_q;
    a_cnt_d = a_cnt_q; b_cnt_d = b_cnt_q;
    si_d = si_q; sj_d = sj_q; sel_b_d = sel_b_q;
    kl_d = kl_q; kh_d = kh_q;
    ca_d = ca_q; cb_d = cb_q; fresh_d = fresh_q;
    min_a_d = min_a_q; max_a_d = max_a_q; min_b_d = min_b_q; max_b_d = max_b_q;
    rn_d = rn_q; oi_d = oi_q; over_d = over_q;
    lt3_d = lt3_q;
    push = 1'b0; push_lo = min_a_q; push_hi = max_a_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(in_data_i.kind))
            KIND_CLEAR: begin a_cnt_d = '0; b_cnt_d = '0; end
            KIND_LOAD_A: if (a_cnt_q < CW'(SET_CAPACITY)) a_cnt_d = a_cnt_q + CW'(1);
            KIND_LOAD_B: if (b_cnt_q < CW'(SET_CAPACITY)) b_cnt_d = b_cnt_q + CW'(1);
            KIND_RUN: begin
              rn_d = '0; over_d = 1'b0; oi_d = '0;
              ca_d = '0; cb_d = '0; fresh_d = 1'b1;
              if (b_cnt_q == '0) begin
                // subtract emits A unsorted: sweep with empty B does exactly that
                state_d = S_SWRD;
              end else begin
                sel_b_d = 1'b0; si_d = CW'(1);
                state_d = S_SORTI;
              end
            end
            default: ;
          endcase
        end
      end
      S_SORTI: begin
        if (si_q >= scnt) begin
          if (sel_b_q) state_d = S_SWRD;
          else begin sel_b_d = 1'b1; si_d = CW'(1); end
        end else state_d = S_SORTR;
      end
      S_SORTR: begin
        kl_d = sel_b_q ? b_lo_q[IW'(si_q)] : a_lo_q[IW'(si_q)];
        kh_d = sel_b_q ? b_hi_q[IW'(si_q)] : a_hi_q[IW'(si_q)];
        sj_d = si_q;
        state_d = S_SORTC;
      end
      S_SORTC: begin
        if (sj_q != '0 && cmp_lt) sj_d = sj_q - CW'(1);
        else state_d = S_SORTW;
      end
      S_SORTW: begin
        si_d = si_q + CW'(1);
        state_d = S_SORTI;
      end
      S_SWRD: begin
        if (ca_q >= a_cnt_q) begin
          state_d = S_OUT;
        end else begin
          if (fresh_q) begin
            min_a_d = a_lo_q[IW'(ca_q)];
            max_a_d = a_hi_q[IW'(ca_q)];
            fresh_d = 1'b0;
          end
          if (cb_q >= b_cnt_q) begin
            if (!isect) begin
              push = 1'b1;
              push_lo = fresh_q ? a_lo_q[IW'(ca_q)] : min_a_q;
              push_hi = fresh_q ? a_hi_q[IW'(ca_q)] : max_a_q;
            end
            ca_d = ca_q + CW'(1); fresh_d = 1'b1;
          end else begin
            min_b_d = b_lo_q[IW'(cb_q)];
            max_b_d = b_hi_q[IW'(cb_q)];
            state_d = S_SWC1;
          end
        end
      end
      S_SWC1: begin
        if (!cmp_lt) begin // max_b <= min_a
          cb_d = cb_q + CW'(1);
          state_d = S_SWRD;
        end else state_d = S_SWC2;
      end
      S_SWC2: begin
        if (!cmp_lt) begin // min_b >= max_a
          if (!isect) push = 1'b1;
          ca_d = ca_q + CW'(1); fresh_d = 1'b1;
          state_d = S_SWRD;
        end else state_d = S_SWC3;
      end
      S_SWC3: begin
        lt3_d = cmp_lt;   // min_a < min_b
        state_d = S_SWC4;
      end
      S_SWC4: begin
        if (isect) begin
          push = 1'b1;
          push_lo = lt3_q ? min_b_q : min_a_q;
          if (cmp_lt) begin
            push_hi = max_b_q;
            min_a_d = max_b_q;
            cb_d = cb_q + CW'(1);
          end else begin
            push_hi = max_a_q;
            ca_d = ca_q + CW'(1); fresh_d = 1'b1;
          end
        end else begin
          push = lt3_q;
          push_lo = min_a_q; push_hi = min_b_q;
          if (cmp_lt) begin
            min_a_d = max_b_q;
            cb_d = cb_q + CW'(1);
          end else begin
            ca_d = ca_q + CW'(1); fresh_d = 1'b1;
          end
        end
        state_d = S_SWRD;
      end
      S_OUT: begin
        if (out_acc) begin
          if (rn_q == '0 || oi_q + RCW'(1) >= rn_q) state_d = S_IDLE;
          else oi_d = oi_q + RCW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (push) begin
      if (rn_q < RCW'(RCap)) rn_d = rn_q + RCW'(1);
      else over_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_cnt_q <= '0; b_cnt_q <= '0; mode_q <= 1'b0;
      rn_q <= '0; oi_q <= '0; over_q <= 1'b0;
      si_q <= '0; sj_q <= '0; sel_b_q <= 1'b0;
      ca_q <= '0; cb_q <= '0; fresh_q <= 1'b1;
    end else begin
      state_q <= state_d;
      a_cnt_q <= a_cnt_d; b_cnt_q <= b_cnt_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      rn_q <= rn_d; oi_q <= oi_d; over_q <= over_d;
      si_q <= si_d; sj_q <= sj_d; sel_b_q <= sel_b_d;
      ca_q <= ca_d; cb_q <= cb_d; fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kl_q <= kl_d; kh_q <= kh_d;
    min_a_q <= min_a_d; max_a_q <= max_a_d;
    min_b_q <= min_b_d; max_b_q <= max_b_d;
    lt3_q <= lt3_d;
  end

  // drive result beat
  always_comb begin
    out_data_o = '0;
    out_data_o.overflowed = over_q;
    if (rn_q == '0) begin
      out_data_o.is_last  = 1'b1;
      out_data_o.is_empty = 1'b1;
    end else begin
      out_data_o.res_lo  = 32'(signed'(r_lo_q[RW'(oi_q)]));
      out_data_o.res_hi  = 32'(signed'(r_hi_q[RW'(oi_q)]));
      out_data_o.is_last = (oi_q + RCW'(1)) == rn_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) rn_q <= RCW'(RCap))
    else $error("result count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_cnt_q <= CW'(SET_CAPACITY) && b_cnt_q <= CW'(SET_CAPACITY))
    else $error("set count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && rn_q != '0 |-> oi_q < rn_q)
    else $error("output index past result count");
endmodule

FILE: src/issi_cmp.sv
// Shared signed compare unit: one less-than compare per cycle for the sequencer.
module issi_cmp #(
  parameter int unsigned EndWidth = issi_pkg::EndWidth
) (
  input  logic [EndWidth-1:0] a_i,
  input  logic [EndWidth-1:0] b_i,
  output logic                lt_o
);
  import issi_pkg::*;

  assign lt_o = $signed(a_i) < $signed(b_i);
endmodule
